// File: rtl/core/vcd_pkg.sv
// Package for the vending change dispenser: widths, codes, token type and coin arithmetic.
`timescale 1ns / 1ps
package vcd_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int OUT_W       = 16;
   localparam int PRICE_W     = 8;
   localparam int COIN_W      = 8;
   localparam int LIMIT_W     = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int NUM_COINS   = 4;
   localparam int NUM_CELLS   = 4;
   // largest deposit value: 255 * (1 + 2 + 5 + 10) = 4590
   localparam int DEP_W       = 13;
   localparam int SUM_W       = ((COUNT_WIDTH > DEP_W) ? COUNT_WIDTH : DEP_W) + 1;
   localparam int RECIP_W     = 2 * COUNT_WIDTH;
   localparam int PROD_W      = 3 * COUNT_WIDTH;

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX     = '1;
   localparam logic [COUNT_WIDTH-1:0] STOCK_RESET = COUNT_WIDTH'(100);
   localparam logic [PRICE_W-1:0]     PRICE_A_RESET = PRICE_W'(40);
   localparam logic [PRICE_W-1:0]     PRICE_B_RESET = PRICE_W'(30);
   localparam logic [PRICE_W-1:0]     PRICE_C_RESET = PRICE_W'(20);
   localparam logic [PRICE_W-1:0]     PRICE_D_RESET = PRICE_W'(10);
   localparam logic [LIMIT_W-1:0]     LIMIT_RESET   = LIMIT_W'(200);

   // reciprocals for divide by 10 and by 5, exact for any COUNT_WIDTH-bit dividend
   localparam logic [RECIP_W-1:0] RECIP_TEN  =
      RECIP_W'({1'b1, {RECIP_W{1'b0}}} / 10 + 1);
   localparam logic [RECIP_W-1:0] RECIP_FIVE =
      RECIP_W'({1'b1, {RECIP_W{1'b0}}} / 5 + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRICE_A = 3'd0,
      CSR_PRICE_B = 3'd1,
      CSR_PRICE_C = 3'd2,
      CSR_PRICE_D = 3'd3,
      CSR_LIMIT   = 3'd4
   } csr_idx_type;

   typedef enum logic {
      OP_SELECT  = 1'b0,
      OP_DEPOSIT = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STAT_OPENED  = 2'd0,
      STAT_SHORT   = 2'd1,
      STAT_DONE    = 2'd2,
      STAT_IGNORED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      COIN_ONE  = 2'd0,
      COIN_TWO  = 2'd1,
      COIN_FIVE = 2'd2,
      COIN_TEN  = 2'd3
   } coin_type;

   typedef coin_type cell_coin_type [NUM_CELLS];
   // change is paid from the largest coin down
   localparam cell_coin_type CELL_COIN = '{COIN_TEN, COIN_FIVE, COIN_TWO, COIN_ONE};

   typedef struct packed {
      status_type                                status;
      logic [PRICE_W-1:0]                        due;
      logic                                      pay;
      logic [COUNT_WIDTH-1:0]                    bal;
      logic [NUM_COINS-1:0][COIN_W-1:0]          add;
      logic [NUM_COINS-1:0][COUNT_WIDTH-1:0]     change;
      logic [NUM_COINS-1:0][COUNT_WIDTH-1:0]     excess;
   } tok_type;

   function automatic logic [COUNT_WIDTH-1:0] sat_add(
      input logic [COUNT_WIDTH-1:0] a,
      input logic [DEP_W-1:0]       b
   );
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(a) + SUM_W'(b);
      return (sum > SUM_W'(CNT_MAX)) ? CNT_MAX : sum[COUNT_WIDTH-1:0];
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] coin_quot(
      input logic [COUNT_WIDTH-1:0] bal,
      input coin_type               coin
   );
      logic [PROD_W-1:0] prod;
      prod = '0;
      case (coin)
         COIN_TEN: begin
            prod = PROD_W'(bal) * PROD_W'(RECIP_TEN);
            return prod[PROD_W-1:RECIP_W];
         end
         COIN_FIVE: begin
            prod = PROD_W'(bal) * PROD_W'(RECIP_FIVE);
            return prod[PROD_W-1:RECIP_W];
         end
         COIN_TWO: return bal >> 1;
         default:  return bal;
      endcase
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] coin_value(
      input logic [COUNT_WIDTH-1:0] cnt,
      input coin_type               coin
   );
      case (coin)
         COIN_TEN:  return (cnt << 3) + (cnt << 1);
         COIN_FIVE: return (cnt << 2) + cnt;
         COIN_TWO:  return cnt << 1;
         default:   return cnt;
      endcase
   endfunction

endpackage

// File: rtl/core/vcd_if.sv
// Request and response channel interfaces of the vending change dispenser.
`timescale 1ns / 1ps
interface vcd_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [1:0] product;
   logic [7:0] coins_one;
   logic [7:0] coins_two;
   logic [7:0] coins_five;
   logic [7:0] coins_ten;

   modport source (
      output valid, op, product, coins_one, coins_two, coins_five, coins_ten,
      input  ready
   );
   modport sink (
      input  valid, op, product, coins_one, coins_two, coins_five, coins_ten,
      output ready
   );
endinterface

interface vcd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  amount_due;
   logic [15:0] change_ten;
   logic [15:0] change_five;
   logic [15:0] change_two;
   logic [15:0] change_one;
   logic [15:0] change_unpaid;
   logic [15:0] excess_one;
   logic [15:0] excess_two;
   logic [15:0] excess_five;
   logic [15:0] excess_ten;

   modport source (
      output valid, status, amount_due, change_ten, change_five, change_two, change_one,
             change_unpaid, excess_one, excess_two, excess_five, excess_ten,
      input  ready
   );
   modport sink (
      input  valid, status, amount_due, change_ten, change_five, change_two, change_one,
             change_unpaid, excess_one, excess_two, excess_five, excess_ten,
      output ready
   );
endinterface

// File: rtl/core/vcd_head.sv
// Sale control stage: price registers, open sale, paid sum; launches tokens into the coin cells.
`timescale 1ns / 1ps
module vcd_head
   import vcd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   vcd_req_if.sink               req_chan,
   output tok_type               tok,
   output logic                  tok_valid,
   input  logic                  tok_ready,
   output logic [LIMIT_W-1:0]    limit
);

   logic [PRICE_W-1:0]     price_a_ff, price_b_ff, price_c_ff, price_d_ff;
   logic [LIMIT_W-1:0]     limit_ff;
   logic                   sale_open_ff, sale_open_in;
   logic [PRICE_W-1:0]     sale_price_ff, sale_price_in;
   logic [COUNT_WIDTH-1:0] paid_ff, paid_in;
   tok_type                tok_ff, tok_in;
   logic                   valid_ff;
   logic                   fire;
   logic [PRICE_W-1:0]     price_sel;
   logic [DEP_W-1:0]       dep_val;
   logic [COUNT_WIDTH-1:0] paid_new;
   logic [COUNT_WIDTH-1:0] price_ext;

   assign req_chan.ready = !valid_ff || tok_ready;
   assign fire           = req_chan.valid && req_chan.ready;
   assign tok            = tok_ff;
   assign tok_valid      = valid_ff;
   assign limit          = limit_ff;

   always_comb begin
      case (req_chan.product)
         2'd0:    price_sel = price_a_ff;
         2'd1:    price_sel = price_b_ff;
         2'd2:    price_sel = price_c_ff;
         default: price_sel = price_d_ff;
      endcase

      dep_val = DEP_W'(req_chan.coins_one)
              + (DEP_W'(req_chan.coins_two) << 1)
              + (DEP_W'(req_chan.coins_five) << 2) + DEP_W'(req_chan.coins_five)
              + (DEP_W'(req_chan.coins_ten) << 3) + (DEP_W'(req_chan.coins_ten) << 1);
      paid_new  = sat_add(paid_ff, dep_val);
      price_ext = COUNT_WIDTH'(sale_price_ff);

      sale_open_in  = sale_open_ff;
      sale_price_in = sale_price_ff;
      paid_in       = paid_ff;
      tok_in        = '0;

      case (op_type'(req_chan.op))
         OP_SELECT: begin
            sale_open_in  = 1'b1;
            sale_price_in = price_sel;
            paid_in       = '0;
            tok_in.status = STAT_OPENED;
            tok_in.due    = price_sel;
         end
         default: begin
            if (!sale_open_ff) begin
               tok_in.status = STAT_IGNORED;
            end else begin
               tok_in.add[COIN_ONE]  = req_chan.coins_one;
               tok_in.add[COIN_TWO]  = req_chan.coins_two;
               tok_in.add[COIN_FIVE] = req_chan.coins_five;
               tok_in.add[COIN_TEN]  = req_chan.coins_ten;
               if (paid_new < price_ext) begin
                  paid_in       = paid_new;
                  tok_in.status = STAT_SHORT;
                  tok_in.due    = PRICE_W'(price_ext - paid_new);
               end else begin
                  sale_open_in  = 1'b0;
                  paid_in       = '0;
                  tok_in.status = STAT_DONE;
                  tok_in.pay    = 1'b1;
                  tok_in.bal    = paid_new - price_ext;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         price_a_ff    <= PRICE_A_RESET;
         price_b_ff    <= PRICE_B_RESET;
         price_c_ff    <= PRICE_C_RESET;
         price_d_ff    <= PRICE_D_RESET;
         limit_ff      <= LIMIT_RESET;
         sale_open_ff  <= 1'b0;
         sale_price_ff <= '0;
         paid_ff       <= '0;
         valid_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_idx_type'(csr_index))
               CSR_PRICE_A: price_a_ff <= csr_wdata[PRICE_W-1:0];
               CSR_PRICE_B: price_b_ff <= csr_wdata[PRICE_W-1:0];
               CSR_PRICE_C: price_c_ff <= csr_wdata[PRICE_W-1:0];
               CSR_PRICE_D: price_d_ff <= csr_wdata[PRICE_W-1:0];
               CSR_LIMIT:   limit_ff   <= csr_wdata[LIMIT_W-1:0];
               default: ;
            endcase
         end
         if (fire) begin
            sale_open_ff  <= sale_open_in;
            sale_price_ff <= sale_price_in;
            paid_ff       <= paid_in;
         end
         if (req_chan.ready) begin
            valid_ff <= req_chan.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         tok_ff <= tok_in;
      end
   end

   a_closed_sale_no_paid: assert property (@(posedge clock) disable iff (reset)
      !sale_open_ff |-> paid_ff == '0)
      else $error("paid sum held while no sale is open");

   a_select_opens: assert property (@(posedge clock) disable iff (reset)
      fire && req_chan.op == OP_SELECT |=> sale_open_ff && valid_ff
         && tok_ff.status == STAT_OPENED)
      else $error("select did not open a sale");

   a_done_closes: assert property (@(posedge clock) disable iff (reset)
      fire && tok_in.status == STAT_DONE |=> !sale_open_ff && tok_ff.pay)
      else $error("completed sale left open");

endmodule

// File: rtl/core/vcd_cell.sv
// Coin cell: holds one denomination's stock, takes deposits, pays greedy change, reports excess.
`timescale 1ns / 1ps
module vcd_cell
   import vcd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  coin_type           coin,
   input  logic [LIMIT_W-1:0] limit,
   input  tok_type            up_tok,
   input  logic               up_valid,
   output logic               up_ready,
   output tok_type            dn_tok,
   output logic               dn_valid,
   input  logic               dn_ready
);

   logic [COUNT_WIDTH-1:0] stock_ff, stock_in;
   tok_type                tok_ff, tok_in;
   logic                   valid_ff;
   logic                   fire;
   logic [COUNT_WIDTH-1:0] stock_sum;
   logic [COUNT_WIDTH-1:0] want;
   logic [COUNT_WIDTH-1:0] give;

   assign up_ready = !valid_ff || dn_ready;
   assign fire     = up_valid && up_ready;
   assign dn_tok   = tok_ff;
   assign dn_valid = valid_ff;

   always_comb begin
      stock_sum = sat_add(stock_ff, DEP_W'(up_tok.add[coin]));
      want      = coin_quot(up_tok.bal, coin);
      give      = up_tok.pay ? ((want < stock_sum) ? want : stock_sum) : '0;
      stock_in  = stock_sum - give;

      tok_in              = up_tok;
      tok_in.bal          = up_tok.bal - coin_value(give, coin);
      tok_in.change[coin] = give;
      tok_in.excess[coin] = (SUM_W'(stock_in) > SUM_W'(limit))
                          ? COUNT_WIDTH'(SUM_W'(stock_in) - SUM_W'(limit)) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stock_ff <= STOCK_RESET;
         valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            stock_ff <= stock_in;
         end
         if (up_ready) begin
            valid_ff <= up_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         tok_ff <= tok_in;
      end
   end

   a_stock_moves_on_transaction: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(stock_ff))
      else $error("coin stock changed without a transaction");

endmodule

// File: rtl/core/vending_change_dispenser.sv
// Top level of the vending change dispenser: sale control stage and a chain of four coin cells.
//
//   channel   direction  handshake          payload
//   req_chan  in         valid / ready      op, product, coins_one/two/five/ten
//   rsp_chan  out        valid / ready      status, amount_due, change_*, excess_*
//   csr_*     in         csr_we, no wait    csr_index, csr_wdata
//
// One transaction per cycle sustained while rsp_chan is ready; each result passes the sale stage,
// loaded at the edge that accepts its request, then the ten, five, two and one coin cells, each
// a register stage.
// Each cell owns its coin stock, so a transaction sees the stock left by the one ahead.
// Synchronous active-high reset restores prices, limit and stocks; no clearing pass.
// Ready is chained back stage by stage: a stalled response holds only the stages behind
// it that are full, and bubbles still fill.
`timescale 1ns / 1ps
module vending_change_dispenser
   import vcd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   vcd_req_if.sink               req_chan,
   vcd_rsp_if.source             rsp_chan
);

   tok_type            tok   [NUM_CELLS+1];
   logic               valid [NUM_CELLS+1];
   logic               ready [NUM_CELLS+1];
   logic [LIMIT_W-1:0] limit;

   vcd_head u_head (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .tok       (tok[0]),
      .tok_valid (valid[0]),
      .tok_ready (ready[0]),
      .limit     (limit)
   );

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      vcd_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .coin     (CELL_COIN[i]),
         .limit    (limit),
         .up_tok   (tok[i]),
         .up_valid (valid[i]),
         .up_ready (ready[i]),
         .dn_tok   (tok[i+1]),
         .dn_valid (valid[i+1]),
         .dn_ready (ready[i+1])
      );
   end

   assign ready[NUM_CELLS]      = rsp_chan.ready;
   assign rsp_chan.valid        = valid[NUM_CELLS];
   assign rsp_chan.status       = tok[NUM_CELLS].status;
   assign rsp_chan.amount_due   = tok[NUM_CELLS].due;
   assign rsp_chan.change_ten   = OUT_W'(tok[NUM_CELLS].change[COIN_TEN]);
   assign rsp_chan.change_five  = OUT_W'(tok[NUM_CELLS].change[COIN_FIVE]);
   assign rsp_chan.change_two   = OUT_W'(tok[NUM_CELLS].change[COIN_TWO]);
   assign rsp_chan.change_one   = OUT_W'(tok[NUM_CELLS].change[COIN_ONE]);
   assign rsp_chan.change_unpaid = OUT_W'(tok[NUM_CELLS].bal);
   assign rsp_chan.excess_one   = OUT_W'(tok[NUM_CELLS].excess[COIN_ONE]);
   assign rsp_chan.excess_two   = OUT_W'(tok[NUM_CELLS].excess[COIN_TWO]);
   assign rsp_chan.excess_five  = OUT_W'(tok[NUM_CELLS].excess[COIN_FIVE]);
   assign rsp_chan.excess_ten   = OUT_W'(tok[NUM_CELLS].excess[COIN_TEN]);

endmodule
